@@ sv/hfcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hfcc_pkg;

  localparam int unsigned FrameLen = 6;
  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcTop = 8'h80;
  localparam logic [7:0] CrcPolyReset = 8'h31;
  localparam int unsigned OutWidth = 40;

  typedef enum logic [2:0] {
    POS_TEMP_HI = 3'd0,
    POS_TEMP_LO = 3'd1,
    POS_TEMP_CRC = 3'd2,
    POS_HUM_HI = 3'd3,
    POS_HUM_LO = 3'd4,
    POS_HUM_CRC = 3'd5
  } byte_pos_t;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_CRC_BAD = 2'd1,
    STATUS_XFER_ERR = 2'd2
  } frame_status_t;

  typedef enum logic {
    REG_CRC_POLY = 1'b0,
    REG_CHECK_CRC = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
    frame_status_t frame_status;
  } frame_result_t;

  typedef struct packed {
    logic result_valid;
    logic [2:0] position;
  } frame_info_t;

endpackage

`default_nettype wire

@@ sv/hfcc_crc8.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfcc_crc8 (
  input  wire logic [7:0] crc_in,
  input  wire logic [7:0] data_in,
  input  wire logic [7:0] poly,
  output logic      [7:0] crc_out
);
  import hfcc_pkg::*;

  // MSB first, one bit per step
  always_comb begin
    logic [7:0] v;
    v = crc_in ^ data_in;
    for (int k = 0; k < 8; k++) begin
      if ((v & CrcTop) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    crc_out = v;
  end

endmodule

`default_nettype wire

@@ sv/hfcc_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfcc_frame (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [7:0]             cfg_data,
  input  wire logic                   in_fire,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   transfer_error,
  output hfcc_pkg::frame_result_t     result,
  output hfcc_pkg::frame_info_t       info
);
  import hfcc_pkg::*;

  logic [7:0] crc_poly;
  logic check_crc;
  logic [2:0] byte_position;
  logic [7:0] running_crc;
  logic [15:0] temperature_word;
  logic [15:0] humidity_word;
  logic crc_bad;
  logic transfer_failed;

  logic [2:0] pos;
  logic [7:0] crc_seed;
  logic [7:0] crc_upd;
  logic crc_miss;

  // out-of-frame positions restart the frame
  assign pos = (byte_position >= 3'(FrameLen)) ? POS_TEMP_HI : byte_position;
  assign crc_seed = (pos == POS_TEMP_HI || pos == POS_HUM_HI) ? CrcInit : running_crc;
  assign crc_miss = running_crc != data_byte;

  hfcc_crc8 u_crc (
    .crc_in (crc_seed),
    .data_in(data_byte),
    .poly   (crc_poly),
    .crc_out(crc_upd)
  );

  always_comb begin
    result.temperature_raw = temperature_word;
    result.humidity_raw = humidity_word;
    if (transfer_failed || transfer_error) begin
      result.frame_status = STATUS_XFER_ERR;
    end else if (check_crc && (crc_bad || crc_miss)) begin
      result.frame_status = STATUS_CRC_BAD;
    end else begin
      result.frame_status = STATUS_OK;
    end
    info.result_valid = pos == POS_HUM_CRC;
    info.position = byte_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly <= CrcPolyReset;
      check_crc <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CRC_POLY: crc_poly <= cfg_data;
        REG_CHECK_CRC: check_crc <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_TEMP_HI;
      running_crc <= CrcInit;
      temperature_word <= '0;
      humidity_word <= '0;
      crc_bad <= 1'b0;
      transfer_failed <= 1'b0;
    end else if (in_fire) begin
      if (pos == POS_HUM_CRC) begin
        byte_position <= POS_TEMP_HI;
        running_crc <= CrcInit;
        temperature_word <= '0;
        humidity_word <= '0;
        crc_bad <= 1'b0;
        transfer_failed <= 1'b0;
      end else begin
        byte_position <= pos + 3'd1;
        if (transfer_error) begin
          transfer_failed <= 1'b1;
        end
        unique case (pos)
          POS_TEMP_HI: begin
            running_crc <= crc_upd;
            temperature_word <= {data_byte, 8'h00};
          end
          POS_TEMP_LO: begin
            running_crc <= crc_upd;
            temperature_word <= {temperature_word[15:8], data_byte};
          end
          POS_TEMP_CRC: begin
            if (crc_miss) begin
              crc_bad <= 1'b1;
            end
            running_crc <= CrcInit;
          end
          POS_HUM_HI: begin
            running_crc <= crc_upd;
            humidity_word <= {data_byte, 8'h00};
          end
          POS_HUM_LO: begin
            running_crc <= crc_upd;
            humidity_word <= {humidity_word[15:8], data_byte};
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/hfcc_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfcc_out_reg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire hfcc_pkg::frame_result_t result,
  output logic                        can_load,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [hfcc_pkg::OutWidth-1:0] m_tdata
);
  import hfcc_pkg::*;

  frame_result_t held;

  function automatic logic [33:0] result_pack(frame_result_t r);
    return {r.frame_status, r.humidity_raw, r.temperature_raw};
  endfunction

  // a waiting result that is taken this cycle frees the slot
  assign can_load = !m_tvalid || m_tready;
  assign m_tdata = {(OutWidth - 34)'(0), result_pack(held)};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

@@ sv/humidity_frame_crc_checker_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Checks six-byte temperature/humidity readouts, one byte per item on the
// slave stream: bytes 0,1 form the temperature word, byte 2 its CRC-8, bytes
// 3,4 the humidity word, byte 5 its CRC-8 (MSB first, init 0xFF, polynomial
// from register 0, no final XOR). After the sixth byte one result appears
// on the master stream in the cycle after, with both words and a status: 0 ok,
// 1 CRC mismatch (only when register 1 is set), 2 transfer error, which
// wins. Each byte passes through a single byte-wide CRC stage;
// a byte is accepted in every cycle except while a finished result waits
// unaccepted in the output register.
module humidity_frame_crc_checker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] transfer_error
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [15:0] temperature_raw, [31:16] humidity_raw,
                                      // [33:32] frame_status, [39:34] zero
);
  import hfcc_pkg::*;

  frame_result_t result;
  frame_info_t info;
  logic in_fire;
  logic can_load;

  assign s_tready = can_load;
  assign in_fire = s_tvalid && s_tready;

  hfcc_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_fire       (in_fire),
    .data_byte     (s_tdata),
    .transfer_error(s_tuser),
    .result        (result),
    .info          (info)
  );

  hfcc_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (in_fire && info.result_valid),
    .result  (result),
    .can_load(can_load),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    info.position <= 3'(FrameLen - 1))
    else $error("byte position left the frame");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && info.result_valid) |=> m_tvalid)
    else $error("sixth byte gave no result");

  a_no_result_early: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && !(in_fire && info.result_valid)) |=> !m_tvalid)
    else $error("result without a sixth byte");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:32] != 2'd3 && m_tdata[39:34] == 6'd0))
    else $error("bad status or padding");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import hfcc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       xfer_err;
  } readout_byte_t;

  typedef enum logic [2:0] {
    FRAME_GOOD,
    FRAME_BAD_TEMP_CRC,
    FRAME_BAD_HUM_CRC,
    FRAME_BAD_BOTH_CRC,
    FRAME_NOISE
  } frame_kind_t;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned FramesPerPhase = 36;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;  // [7:0] data_byte
  logic        s_tuser = 1'b0; // [0] transfer_error
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // [15:0] temperature_raw, [31:16] humidity_raw,
                              // [33:32] frame_status, [39:34] zero

  // shadow of the block's registers and frame state
  logic [7:0]  poly_cfg = CrcPolyReset;
  logic        check_cfg = 1'b1;
  byte_pos_t   frame_pos = POS_TEMP_HI;
  logic [7:0]  crc_acc = CrcInit;
  logic [15:0] temp_word = '0;
  logic [15:0] hum_word = '0;
  logic        crc_mismatch = 1'b0;
  logic        xfer_seen = 1'b0;

  readout_byte_t pending_bytes[$];
  frame_result_t expected_frames[$];
  int unsigned   errors = 0;
  int unsigned   cycle_count = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  bit            rx_hold_req = 1'b0;
  bit            rx_hold_taken = 1'b0;
  int unsigned   rx_hold_left = 0;

  humidity_frame_crc_checker_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] data,
                                          logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((v & CrcTop) != 8'h00) v = (v << 1) ^ poly;
      else v = v << 1;
    end
    return v;
  endfunction

  // advance the frame state by one accepted byte
  task automatic absorb_byte(input readout_byte_t item);
    frame_result_t res;
    if (item.xfer_err) xfer_seen = 1'b1;
    case (frame_pos)
      POS_TEMP_HI: begin
        crc_acc = crc_fold(CrcInit, item.data, poly_cfg);
        temp_word = {item.data, 8'h00};
      end
      POS_TEMP_LO: begin
        crc_acc = crc_fold(crc_acc, item.data, poly_cfg);
        temp_word[7:0] = item.data;
      end
      POS_TEMP_CRC: begin
        if (crc_acc != item.data) crc_mismatch = 1'b1;
        crc_acc = CrcInit;
      end
      POS_HUM_HI: begin
        crc_acc = crc_fold(CrcInit, item.data, poly_cfg);
        hum_word = {item.data, 8'h00};
      end
      POS_HUM_LO: begin
        crc_acc = crc_fold(crc_acc, item.data, poly_cfg);
        hum_word[7:0] = item.data;
      end
      default: begin
        if (crc_acc != item.data) crc_mismatch = 1'b1;
        res.temperature_raw = temp_word;
        res.humidity_raw = hum_word;
        // a transfer error wins over a CRC mismatch
        if (xfer_seen) res.frame_status = STATUS_XFER_ERR;
        else if (check_cfg && crc_mismatch) res.frame_status = STATUS_CRC_BAD;
        else res.frame_status = STATUS_OK;
        expected_frames.push_back(res);
        crc_acc = CrcInit;
        temp_word = '0;
        hum_word = '0;
        crc_mismatch = 1'b0;
        xfer_seen = 1'b0;
      end
    endcase
    if (frame_pos == POS_HUM_CRC) frame_pos = POS_TEMP_HI;
    else frame_pos = byte_pos_t'(frame_pos + 3'd1);
  endtask

  // build one readout with the current polynomial and queue bytes from_byte..to_byte
  task automatic queue_frame(input frame_kind_t kind, input logic [15:0] temp,
                             input logic [15:0] hum, input logic [5:0] err_mask,
                             input int from_byte, input int to_byte);
    logic [7:0] frame [6];
    frame[0] = temp[15:8];
    frame[1] = temp[7:0];
    frame[2] = crc_fold(crc_fold(CrcInit, temp[15:8], poly_cfg), temp[7:0], poly_cfg);
    frame[3] = hum[15:8];
    frame[4] = hum[7:0];
    frame[5] = crc_fold(crc_fold(CrcInit, hum[15:8], poly_cfg), hum[7:0], poly_cfg);
    case (kind)
      FRAME_BAD_TEMP_CRC: frame[2] ^= 8'($urandom_range(1, 255));
      FRAME_BAD_HUM_CRC:  frame[5] ^= 8'($urandom_range(1, 255));
      FRAME_BAD_BOTH_CRC: begin
        frame[2] ^= 8'($urandom_range(1, 255));
        frame[5] ^= 8'($urandom_range(1, 255));
      end
      FRAME_NOISE: begin
        for (int k = 0; k < 6; k++) frame[k] = 8'($urandom);
      end
      default: ;
    endcase
    for (int k = from_byte; k <= to_byte; k++) begin
      pending_bytes.push_back('{data: frame[k], xfer_err: err_mask[k]});
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CRC_POLY) poly_cfg = value;
    else check_cfg = value[0];
  endtask

  // hold until every byte is taken and every result is back, then let the block settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_frames.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    readout_byte_t next_item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_byte('{data: s_tdata, xfer_err: s_tuser});
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && (tx_quiet || $urandom_range(0, 99) >= 31)) begin
          next_item = pending_bytes.pop_front();
          s_tdata <= next_item.data;
          s_tuser <= next_item.xfer_err;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: result with none expected, got %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          if (m_tdata[15:0] !== want.temperature_raw) begin
            $display("%0t: temperature_raw expected %h got %h", $time,
                     want.temperature_raw, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[31:16] !== want.humidity_raw) begin
            $display("%0t: humidity_raw expected %h got %h", $time,
                     want.humidity_raw, m_tdata[31:16]);
            errors++;
          end
          if (m_tdata[33:32] !== want.frame_status) begin
            $display("%0t: frame_status expected %0d got %0d", $time,
                     want.frame_status, m_tdata[33:32]);
            errors++;
          end
        end
      end
      if (rx_hold_req && !rx_hold_taken) begin
        rx_hold_left = RxHoldCycles;
        rx_hold_taken = 1'b1;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= rx_quiet || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [7:0]  phase_poly [PhaseCount];
    logic        phase_check [PhaseCount];
    frame_kind_t kind;
    logic [5:0]  err_mask;
    int unsigned pick;

    phase_poly = '{8'h31, 8'h00, 8'hFF, 8'hFF, 8'h07, 8'h80, 8'($urandom), 8'($urandom)};
    phase_check = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'($urandom)};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, each status, error on the CRC byte, check off mid-frame
    @(negedge clk);
    queue_frame(FRAME_GOOD, 16'h0000, 16'hFFFF, 6'b000000, 0, 5);
    queue_frame(FRAME_BAD_HUM_CRC, 16'hFFFF, 16'h0000, 6'b000000, 0, 5);
    queue_frame(FRAME_BAD_TEMP_CRC, 16'h8001, 16'h7FFE, 6'b100000, 0, 5);
    queue_frame(FRAME_BAD_TEMP_CRC, 16'h1234, 16'hABCD, 6'b000000, 0, 2);
    wait_drained();
    write_reg(REG_CRC_POLY, 8'h07);
    write_reg(REG_CHECK_CRC, 8'h00);
    @(negedge clk);
    queue_frame(FRAME_GOOD, 16'h1234, 16'hABCD, 6'b000000, 3, 5);
    wait_drained();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      write_reg(REG_CRC_POLY, phase_poly[phase]);
      write_reg(REG_CHECK_CRC, {7'b0, phase_check[phase]});
      @(negedge clk);
      // phase 1: sender keeps offering while the receiver holds off
      // phase 2: no idling on either side
      tx_quiet = (phase == 1) || (phase == 2);
      rx_quiet = (phase == 2);
      if (phase == 1) rx_hold_req = 1'b1;
      for (int n = 0; n < FramesPerPhase; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) kind = FRAME_GOOD;
        else if (pick < 72) kind = FRAME_BAD_TEMP_CRC;
        else if (pick < 84) kind = FRAME_BAD_HUM_CRC;
        else if (pick < 90) kind = FRAME_BAD_BOTH_CRC;
        else kind = FRAME_NOISE;
        err_mask = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(1, 63)) : 6'b000000;
        queue_frame(kind, 16'($urandom), 16'($urandom), err_mask, 0, 5);
      end
      wait_drained();
    end

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
